// ===== src/htlp_pkg.sv =====
// ----------------------------------------------------------------------------
// htlp_pkg
// Shared constants and codes for the handle table with linear probing.
// ----------------------------------------------------------------------------
`default_nettype none
package htlp_pkg;

  localparam int          SLOTS_DEF   = 64;
  localparam int          MAX_RESULTS = 48;
  localparam logic [63:0] GOLDEN      = 64'h9E3779B97F4A7C15;
  localparam logic [62:0] HANDLE_MAX  = 63'h7FFFFFFFFFFFFFFF;

  localparam logic [1:0] KIND_STORE   = 2'd0;
  localparam logic [1:0] KIND_LOOKUP  = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;
  localparam logic [1:0] KIND_REL_CTX = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

endpackage
`default_nettype wire

// ===== src/htlp_in_if.sv =====
// ----------------------------------------------------------------------------
// htlp_in_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
`default_nettype none
interface htlp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [62:0] handle;
  logic [31:0] context_id;
  logic [63:0] payload;

  modport source (output valid, kind, handle, context_id, payload, input ready);
  modport sink   (input valid, kind, handle, context_id, payload, output ready);
endinterface
`default_nettype wire

// ===== src/htlp_out_if.sv =====
// ----------------------------------------------------------------------------
// htlp_out_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
`default_nettype none
interface htlp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [62:0] result_handle;
  logic [31:0] result_context;
  logic [63:0] result_payload;
  logic        last;

  modport source (output valid, status, result_handle, result_context, result_payload,
                  last, input ready);
  modport sink   (input valid, status, result_handle, result_context, result_payload,
                  last, output ready);
endinterface
`default_nettype wire

// ===== src/htlp_ram.sv =====
// ----------------------------------------------------------------------------
// htlp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module htlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/handle_table_linear_probe_core.sv =====
// ----------------------------------------------------------------------------
// handle_table_linear_probe_core
// Handle allocator over an open-addressed table: multiplicative hash, linear
// probe, tombstones, sweep through a side store at three-quarter load.
// ----------------------------------------------------------------------------
//  channel | direction | handshake       | payload
//  in_ch   | sink      | valid && ready  | kind, handle, context_id, payload
//  out_ch  | source    | valid && ready  | status, result_handle/context/payload, last
//
//  One request at a time; in_ch.ready is high only while the sequencer idles.
//  Hash: multiply on the shared 32x32 multiplier, then (when SLOTS is not a
//  power of two) a bit-serial remainder. Each probed slot needs a RAM read.
//  Lookup/release and store each hash the handle, then probe from its home
//  slot. Release by context walks the table until its end or MAX_RESULTS
//  matches, plus stalls on out_ch. A sweep reads every slot, then rehashes
//  and probes each live entry. Reset clears all slot valid bits at once.
// ----------------------------------------------------------------------------
`default_nettype none
module handle_table_linear_probe_core
  import htlp_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  htlp_in_if.sink   in_ch,
  htlp_out_if.source out_ch
);

  localparam int IDXW = $clog2(SLOTS);
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int LW   = CW + 3;
  localparam int KW   = $clog2(MAX_RESULTS + 1);
  localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_SWS_RD = 4'd2;
  localparam logic [3:0] S_SWS_EV = 4'd3;
  localparam logic [3:0] S_SWI_RD = 4'd4;
  localparam logic [3:0] S_SWI_EV = 4'd5;
  localparam logic [3:0] S_HASH   = 4'd6;
  localparam logic [3:0] S_PRB_RD = 4'd7;
  localparam logic [3:0] S_PRB_EV = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;
  localparam logic [3:0] S_RC_RD  = 4'd11;
  localparam logic [3:0] S_RC_EV  = 4'd12;
  localparam logic [3:0] S_RC_END = 4'd13;

  // registers
  logic [3:0]      state_r, state_nxt;
  logic [IDXW-1:0] addr_r, addr_nxt;
  logic [IDXW-1:0] start_r, start_nxt;
  logic [IDXW-1:0] tidx_r, tidx_nxt;
  logic            have_tomb_r, have_tomb_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [1:0]      res_mark_r, res_mark_nxt;
  logic            hit_r, hit_nxt;
  logic [62:0]     key_r, key_nxt;
  logic [1:0]      kind_r, kind_nxt;
  logic [31:0]     ctx_r, ctx_nxt;
  logic [63:0]     pay_r, pay_nxt;
  logic [5:0]      hstep_r, hstep_nxt;
  logic [63:0]     prod_r, prod_nxt;
  logic [31:0]     acc_r, acc_nxt;
  logic [IDXW-1:0] rem_r, rem_nxt;
  logic [CW-1:0]   live_r, live_nxt;
  logic [CW-1:0]   tomb_r, tomb_nxt;
  logic [62:0]     next_id_r, next_id_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [CW-1:0]   n_r, n_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic            sw_mode_r, sw_mode_nxt;
  logic            pend_v_r, pend_v_nxt;
  logic [1:0]      pend_st_r, pend_st_nxt;
  logic [62:0]     pend_h_r, pend_h_nxt;
  logic [31:0]     pend_c_r, pend_c_nxt;
  logic [63:0]     pend_p_r, pend_p_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_st_r, out_st_nxt;
  logic [62:0]     out_h_r, out_h_nxt;
  logic [31:0]     out_c_r, out_c_nxt;
  logic [63:0]     out_p_r, out_p_nxt;
  logic            out_last_r, out_last_nxt;

  // memory ports
  logic        slot_we, mark_we, tmp_we;
  logic [1:0]  mark_wd, mark_q;
  logic [62:0] key_q, tkey_q;
  logic [31:0] ctx_q, tctx_q, ctx_wd;
  logic [63:0] pay_q, tpay_q, pay_wd;

  // shared hash unit
  logic [31:0]     mul_a, mul_b;
  logic [4:0]      bsel;
  logic [IDXW:0]   rem_sh;
  logic [IDXW:0]   rem_step;
  logic            hash_done;
  logic [IDXW-1:0] home;

  // misc
  logic [1:0]      mark_eff;
  logic            load_full, sweep_ok;
  logic            tomb_here, ht;
  logic [IDXW-1:0] ti, next_idx;
  logic            ctx_match;

  htlp_ram #(.WIDTH(63), .DEPTH(SLOTS)) u_key (
    .clk, .we(slot_we), .waddr(addr_r), .wdata(key_r), .raddr(addr_r), .rdata(key_q));
  htlp_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_ctx (
    .clk, .we(slot_we), .waddr(addr_r), .wdata(ctx_wd), .raddr(addr_r), .rdata(ctx_q));
  htlp_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_pay (
    .clk, .we(slot_we), .waddr(addr_r), .wdata(pay_wd), .raddr(addr_r), .rdata(pay_q));
  htlp_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_mark (
    .clk, .we(mark_we), .waddr(addr_r), .wdata(mark_wd), .raddr(addr_r), .rdata(mark_q));

  htlp_ram #(.WIDTH(63), .DEPTH(SLOTS)) u_tkey (
    .clk, .we(tmp_we), .waddr(n_r[IDXW-1:0]), .wdata(key_q), .raddr(j_r[IDXW-1:0]),
    .rdata(tkey_q));
  htlp_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_tctx (
    .clk, .we(tmp_we), .waddr(n_r[IDXW-1:0]), .wdata(ctx_q), .raddr(j_r[IDXW-1:0]),
    .rdata(tctx_q));
  htlp_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_tpay (
    .clk, .we(tmp_we), .waddr(n_r[IDXW-1:0]), .wdata(pay_q), .raddr(j_r[IDXW-1:0]),
    .rdata(tpay_q));

  assign ctx_wd = sw_mode_r ? tctx_q : ctx_r;
  assign pay_wd = sw_mode_r ? tpay_q : pay_r;

  assign mark_eff  = valid_r[addr_r] ? mark_q : MARK_EMPTY;
  assign load_full = ((LW'(live_r) + LW'(tomb_r)) << 2) >= LW'(SLOTS * 3);
  assign sweep_ok  = (LW'(tomb_r) << 1) > LW'(live_r);
  assign next_idx  = (addr_r == LAST_IDX) ? '0 : addr_r + 1'b1;
  assign tomb_here = (mark_eff == MARK_TOMB) && !have_tomb_r;
  assign ht        = have_tomb_r || tomb_here;
  assign ti        = have_tomb_r ? tidx_r : addr_r;
  assign ctx_match = (mark_eff == MARK_LIVE) && (ctx_q == ctx_r);

  // multiplier operand select: low*low, low*high, high*low
  always_comb begin
    case (hstep_r)
      6'd0:    begin mul_a = key_r[31:0];          mul_b = GOLDEN[31:0];  end
      6'd1:    begin mul_a = key_r[31:0];          mul_b = GOLDEN[63:32]; end
      default: begin mul_a = {1'b0, key_r[62:32]}; mul_b = GOLDEN[31:0];  end
    endcase
  end

  assign bsel     = 5'(6'd35 - hstep_r);
  assign rem_sh   = {rem_r, acc_r[bsel]};
  assign rem_step = (rem_sh >= (IDXW + 1)'(SLOTS)) ? rem_sh - (IDXW + 1)'(SLOTS) : rem_sh;
  assign hash_done = POW2 ? (hstep_r == 6'd4) : (hstep_r == 6'd35);
  assign home      = POW2 ? acc_r[IDXW-1:0] : rem_step[IDXW-1:0];

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    start_nxt     = start_r;
    tidx_nxt      = tidx_r;
    have_tomb_nxt = have_tomb_r;
    cnt_nxt       = cnt_r;
    res_mark_nxt  = res_mark_r;
    hit_nxt       = hit_r;
    key_nxt       = key_r;
    kind_nxt      = kind_r;
    ctx_nxt       = ctx_r;
    pay_nxt       = pay_r;
    hstep_nxt     = hstep_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    live_nxt      = live_r;
    tomb_nxt      = tomb_r;
    next_id_nxt   = next_id_r;
    valid_nxt     = valid_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    sw_mode_nxt   = sw_mode_r;
    pend_v_nxt    = pend_v_r;
    pend_st_nxt   = pend_st_r;
    pend_h_nxt    = pend_h_r;
    pend_c_nxt    = pend_c_r;
    pend_p_nxt    = pend_p_r;
    out_valid_nxt = out_valid_r;
    out_st_nxt    = out_st_r;
    out_h_nxt     = out_h_r;
    out_c_nxt     = out_c_r;
    out_p_nxt     = out_p_r;
    out_last_nxt  = out_last_r;
    slot_we       = 1'b0;
    mark_we       = 1'b0;
    mark_wd       = MARK_LIVE;
    tmp_we        = 1'b0;

    // drop the result once the sink takes it
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt    = in_ch.kind;
          ctx_nxt     = in_ch.context_id;
          pay_nxt     = in_ch.payload;
          sw_mode_nxt = 1'b0;
          k_nxt       = '0;
          pend_v_nxt  = 1'b0;
          if (in_ch.kind == KIND_STORE) begin
            state_nxt = S_LOAD;
          end else if (in_ch.kind == KIND_REL_CTX) begin
            addr_nxt  = '0;
            state_nxt = S_RC_RD;
          end else begin
            key_nxt   = in_ch.handle;
            hstep_nxt = '0;
            state_nxt = S_HASH;
          end
        end
      end
      S_LOAD: begin
        if (load_full && sweep_ok) begin
          addr_nxt  = '0;
          n_nxt     = '0;
          state_nxt = S_SWS_RD;
        end else if (load_full) begin
          pend_st_nxt = ST_FULL;
          pend_h_nxt  = '0;
          pend_c_nxt  = '0;
          pend_p_nxt  = '0;
          state_nxt   = S_EMIT;
        end else begin
          key_nxt   = next_id_r;
          hstep_nxt = '0;
          state_nxt = S_HASH;
        end
      end
      S_SWS_RD: state_nxt = S_SWS_EV;
      S_SWS_EV: begin
        // gather live entries into the side store
        if (mark_eff == MARK_LIVE) begin
          tmp_we = 1'b1;
          n_nxt  = n_r + 1'b1;
        end
        if (addr_r == LAST_IDX) begin
          valid_nxt = '0;
          live_nxt  = '0;
          tomb_nxt  = '0;
          if (n_r == '0 && mark_eff != MARK_LIVE) begin
            key_nxt   = next_id_r;
            hstep_nxt = '0;
            state_nxt = S_HASH;
          end else begin
            j_nxt       = '0;
            sw_mode_nxt = 1'b1;
            state_nxt   = S_SWI_RD;
          end
        end else begin
          addr_nxt  = next_idx;
          state_nxt = S_SWS_RD;
        end
      end
      S_SWI_RD: state_nxt = S_SWI_EV;
      S_SWI_EV: begin
        key_nxt   = tkey_q;
        hstep_nxt = '0;
        state_nxt = S_HASH;
      end
      S_HASH: begin
        hstep_nxt = hstep_r + 1'b1;
        if (hstep_r <= 6'd2) begin
          prod_nxt = mul_a * mul_b;
        end
        if (hstep_r == 6'd1) begin
          acc_nxt = prod_r[63:32];
        end else if (hstep_r == 6'd2 || hstep_r == 6'd3) begin
          acc_nxt = acc_r + prod_r[31:0];
        end
        if (hstep_r == 6'd3) begin
          rem_nxt = '0;
        end else if (hstep_r >= 6'd4) begin
          rem_nxt = rem_step[IDXW-1:0];
        end
        if (hash_done) begin
          addr_nxt      = home;
          start_nxt     = home;
          have_tomb_nxt = 1'b0;
          cnt_nxt       = '0;
          state_nxt     = S_PRB_RD;
        end
      end
      S_PRB_RD: state_nxt = S_PRB_EV;
      S_PRB_EV: begin
        if (mark_eff == MARK_EMPTY) begin
          addr_nxt     = have_tomb_r ? tidx_r : addr_r;
          res_mark_nxt = have_tomb_r ? MARK_TOMB : MARK_EMPTY;
          hit_nxt      = 1'b0;
          state_nxt    = S_DONE;
        end else if (mark_eff == MARK_LIVE && key_q == key_r) begin
          res_mark_nxt = MARK_LIVE;
          hit_nxt      = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          have_tomb_nxt = ht;
          tidx_nxt      = ti;
          cnt_nxt       = cnt_r + 1'b1;
          if (cnt_r + 1'b1 == CW'(SLOTS)) begin
            // whole table walked: fall back to the first tomb or the start
            addr_nxt     = ht ? ti : start_r;
            res_mark_nxt = ht ? MARK_TOMB : MARK_LIVE;
            hit_nxt      = 1'b0;
            state_nxt    = S_DONE;
          end else begin
            addr_nxt  = next_idx;
            state_nxt = S_PRB_RD;
          end
        end
      end
      S_DONE: begin
        if (sw_mode_r) begin
          slot_we          = 1'b1;
          mark_we          = 1'b1;
          mark_wd          = MARK_LIVE;
          valid_nxt[addr_r] = 1'b1;
          live_nxt         = live_r + 1'b1;
          j_nxt            = j_r + 1'b1;
          if (j_r + 1'b1 == n_r) begin
            sw_mode_nxt = 1'b0;
            key_nxt     = next_id_r;
            hstep_nxt   = '0;
            state_nxt   = S_HASH;
          end else begin
            state_nxt = S_SWI_RD;
          end
        end else begin
          state_nxt = S_EMIT;
          case (kind_r)
            KIND_STORE: begin
              if (res_mark_r == MARK_LIVE) begin
                pend_st_nxt = ST_FULL;
                pend_h_nxt  = '0;
                pend_c_nxt  = '0;
                pend_p_nxt  = '0;
              end else begin
                slot_we           = 1'b1;
                mark_we           = 1'b1;
                mark_wd           = MARK_LIVE;
                valid_nxt[addr_r] = 1'b1;
                live_nxt          = live_r + 1'b1;
                if (res_mark_r == MARK_TOMB) begin
                  tomb_nxt = tomb_r - 1'b1;
                end
                next_id_nxt = (key_r == HANDLE_MAX) ? 63'd1 : key_r + 63'd1;
                pend_st_nxt = ST_OK;
                pend_h_nxt  = key_r;
                pend_c_nxt  = ctx_r;
                pend_p_nxt  = pay_r;
              end
            end
            default: begin
              if (hit_r) begin
                pend_st_nxt = ST_OK;
                pend_h_nxt  = key_r;
                pend_c_nxt  = ctx_q;
                pend_p_nxt  = pay_q;
                if (kind_r == KIND_RELEASE) begin
                  mark_we  = 1'b1;
                  mark_wd  = MARK_TOMB;
                  live_nxt = live_r - 1'b1;
                  tomb_nxt = tomb_r + 1'b1;
                end
              end else begin
                pend_st_nxt = ST_NOT_FOUND;
                pend_h_nxt  = '0;
                pend_c_nxt  = '0;
                pend_p_nxt  = '0;
              end
            end
          endcase
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = pend_st_r;
          out_h_nxt     = pend_h_r;
          out_c_nxt     = pend_c_r;
          out_p_nxt     = pend_p_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      S_RC_RD: state_nxt = S_RC_EV;
      S_RC_EV: begin
        if (ctx_match) begin
          // hold until the previous match can move to the output register
          if (!(pend_v_r && out_valid_r && !out_ch.ready)) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_st_nxt    = pend_st_r;
              out_h_nxt     = pend_h_r;
              out_c_nxt     = pend_c_r;
              out_p_nxt     = pend_p_r;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt  = 1'b1;
            pend_st_nxt = ST_OK;
            pend_h_nxt  = key_q;
            pend_c_nxt  = ctx_q;
            pend_p_nxt  = pay_q;
            mark_we     = 1'b1;
            mark_wd     = MARK_TOMB;
            live_nxt    = live_r - 1'b1;
            tomb_nxt    = tomb_r + 1'b1;
            k_nxt       = k_r + 1'b1;
            if (k_r + 1'b1 == KW'(MAX_RESULTS) || addr_r == LAST_IDX) begin
              state_nxt = S_RC_END;
            end else begin
              addr_nxt  = next_idx;
              state_nxt = S_RC_RD;
            end
          end
        end else if (addr_r == LAST_IDX) begin
          state_nxt = S_RC_END;
        end else begin
          addr_nxt  = next_idx;
          state_nxt = S_RC_RD;
        end
      end
      S_RC_END: begin
        if (!pend_v_r) begin
          pend_st_nxt = ST_NOT_FOUND;
          pend_h_nxt  = '0;
          pend_c_nxt  = '0;
          pend_p_nxt  = '0;
        end
        state_nxt = S_EMIT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      tomb_r      <= '0;
      next_id_r   <= 63'd1;
      valid_r     <= '0;
      sw_mode_r   <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      tomb_r      <= tomb_nxt;
      next_id_r   <= next_id_nxt;
      valid_r     <= valid_nxt;
      sw_mode_r   <= sw_mode_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r      <= addr_nxt;
    start_r     <= start_nxt;
    tidx_r      <= tidx_nxt;
    have_tomb_r <= have_tomb_nxt;
    cnt_r       <= cnt_nxt;
    res_mark_r  <= res_mark_nxt;
    hit_r       <= hit_nxt;
    key_r       <= key_nxt;
    kind_r      <= kind_nxt;
    ctx_r       <= ctx_nxt;
    pay_r       <= pay_nxt;
    hstep_r     <= hstep_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    rem_r       <= rem_nxt;
    n_r         <= n_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    pend_st_r   <= pend_st_nxt;
    pend_h_r    <= pend_h_nxt;
    pend_c_r    <= pend_c_nxt;
    pend_p_r    <= pend_p_nxt;
    out_st_r    <= out_st_nxt;
    out_h_r     <= out_h_nxt;
    out_c_r     <= out_c_nxt;
    out_p_r     <= out_p_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_st_r;
  assign out_ch.result_handle  = out_h_r;
  assign out_ch.result_context = out_c_r;
  assign out_ch.result_payload = out_p_r;
  assign out_ch.last           = out_last_r;

  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    (CW + 1)'(live_r) + (CW + 1)'(tomb_r) <= (CW + 1)'(SLOTS))
    else $error("live plus tomb count exceeds table size");

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r != S_IDLE)
    else $error("request transfer did not start the sequencer");

  a_handle_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    next_id_r != 63'd0)
    else $error("next handle became zero");

endmodule
`default_nettype wire

// ===== dv/handle_table_linear_probe_core_tb.sv =====
// ----------------------------------------------------------------------------
// handle_table_linear_probe_core_tb
// Self-checking bench for the handle table: directed and random store,
// lookup, release and release-by-context requests under varied idling on both
// channels. A behavioral copy of the table predicts every result.
// ----------------------------------------------------------------------------
module handle_table_linear_probe_core_tb;
  import htlp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT     = SLOTS_DEF;
  localparam int WDOG_MAX  = 20000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [62:0] handle;
    logic [31:0] ctx;
    logic [63:0] pay;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [62:0] handle;
    logic [31:0] ctx;
    logic [63:0] pay;
    logic        last;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  htlp_in_if  in_ch();
  htlp_out_if out_ch();

  handle_table_linear_probe_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // table copy
  logic [62:0] tbl_key [NSLOT];
  logic [31:0] tbl_ctx [NSLOT];
  logic [63:0] tbl_pay [NSLOT];
  logic [1:0]  tbl_mark[NSLOT];
  int          n_live;
  int          n_tomb;
  logic [62:0] next_handle;

  req_t req_q[$];
  rsp_t rsp_q[$];
  int   send_idle;
  int   recv_idle;
  int   hold_cycles;
  int   n_pushed;
  int   n_taken;
  int   n_err;
  int   wdog;
  bit   took;
  int   stores_issued;

  function automatic int home_slot(logic [62:0] key);
    logic [63:0] prod;
    prod = {1'b0, key} * GOLDEN;
    return int'(prod[63:32] % NSLOT);
  endfunction

  task automatic probe(input logic [62:0] key, output int idx, output bit hit);
    int  i;
    int  tomb_at;
    bit  have_tomb;
    i = home_slot(key);
    have_tomb = 0;
    tomb_at = 0;
    hit = 0;
    idx = -1;
    for (int n = 0; n < NSLOT; n++) begin
      if (tbl_mark[i] == MARK_EMPTY) begin
        idx = have_tomb ? tomb_at : i;
        return;
      end
      if (tbl_mark[i] == MARK_LIVE && tbl_key[i] == key) begin
        idx = i;
        hit = 1;
        return;
      end
      if (tbl_mark[i] == MARK_TOMB && !have_tomb) begin
        tomb_at = i;
        have_tomb = 1;
      end
      i = (i + 1) % NSLOT;
    end
    idx = have_tomb ? tomb_at : home_slot(key);
  endtask

  task automatic sweep_table();
    logic [62:0] k[$];
    logic [31:0] c[$];
    logic [63:0] p[$];
    int idx;
    bit hit;
    for (int i = 0; i < NSLOT; i++) begin
      if (tbl_mark[i] == MARK_LIVE) begin
        k.push_back(tbl_key[i]);
        c.push_back(tbl_ctx[i]);
        p.push_back(tbl_pay[i]);
      end
      tbl_mark[i] = MARK_EMPTY;
    end
    n_live = 0;
    n_tomb = 0;
    foreach (k[j]) begin
      probe(k[j], idx, hit);
      tbl_key[idx]  = k[j];
      tbl_ctx[idx]  = c[j];
      tbl_pay[idx]  = p[j];
      tbl_mark[idx] = MARK_LIVE;
      n_live++;
    end
  endtask

  function automatic rsp_t mk(logic [1:0] st, logic [62:0] h, logic [31:0] c,
                              logic [63:0] p, logic l);
    rsp_t r;
    r.status = st; r.handle = h; r.ctx = c; r.pay = p; r.last = l;
    return r;
  endfunction

  task automatic predict_request(input req_t r);
    int          idx;
    bit          hit;
    logic [62:0] h;
    int          cnt;
    case (r.kind)
      KIND_STORE: begin
        if ((n_live + n_tomb) * 4 >= NSLOT * 3) begin
          if (n_tomb * 2 > n_live) begin
            sweep_table();
          end else begin
            rsp_q.push_back(mk(ST_FULL, '0, '0, '0, 1'b1));
            return;
          end
        end
        h = (next_handle == '0) ? 63'd1 : next_handle;
        probe(h, idx, hit);
        if (tbl_mark[idx] == MARK_LIVE) begin
          rsp_q.push_back(mk(ST_FULL, '0, '0, '0, 1'b1));
          return;
        end
        next_handle = (h == HANDLE_MAX) ? 63'd1 : h + 63'd1;
        if (tbl_mark[idx] == MARK_TOMB) n_tomb--;
        tbl_key[idx]  = h;
        tbl_ctx[idx]  = r.ctx;
        tbl_pay[idx]  = r.pay;
        tbl_mark[idx] = MARK_LIVE;
        n_live++;
        rsp_q.push_back(mk(ST_OK, h, r.ctx, r.pay, 1'b1));
      end
      KIND_LOOKUP, KIND_RELEASE: begin
        probe(r.handle, idx, hit);
        if (!hit) begin
          rsp_q.push_back(mk(ST_NOT_FOUND, '0, '0, '0, 1'b1));
          return;
        end
        rsp_q.push_back(mk(ST_OK, r.handle, tbl_ctx[idx], tbl_pay[idx], 1'b1));
        if (r.kind == KIND_RELEASE) begin
          tbl_mark[idx] = MARK_TOMB;
          n_live--;
          n_tomb++;
        end
      end
      default: begin
        cnt = 0;
        for (int i = 0; i < NSLOT && cnt < MAX_RESULTS; i++) begin
          if (tbl_mark[i] == MARK_LIVE && tbl_ctx[i] == r.ctx) begin
            rsp_q.push_back(mk(ST_OK, tbl_key[i], tbl_ctx[i], tbl_pay[i], 1'b0));
            tbl_mark[i] = MARK_TOMB;
            n_live--;
            n_tomb++;
            cnt++;
          end
        end
        if (cnt == 0) rsp_q.push_back(mk(ST_NOT_FOUND, '0, '0, '0, 1'b1));
        else rsp_q[$].last = 1'b1;
      end
    endcase
  endtask

  // driver: launch on the falling edge, record transfers on the rising edge
  always @(negedge clk) begin
    req_t r;
    if (rst_n && (!in_ch.valid || took)) begin
      took = 0;
      if (req_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        r = req_q.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= r.kind;
        in_ch.handle     <= r.handle;
        in_ch.context_id <= r.ctx;
        in_ch.payload    <= r.pay;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    req_t r;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      r.kind = in_ch.kind; r.handle = in_ch.handle;
      r.ctx = in_ch.context_id; r.pay = in_ch.payload;
      predict_request(r);
      n_taken++;
      took = 1;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = mk(out_ch.status, out_ch.result_handle, out_ch.result_context,
               out_ch.result_payload, out_ch.last);
      if (rsp_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result: %p", got);
      end else begin
        want = rsp_q.pop_front();
        if (got !== want) begin
          n_err++;
          if (n_err <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      wdog <= 0;
    end else if (wdog >= WDOG_MAX) begin
      $display("simulation failed");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  task automatic push_req(logic [1:0] k, logic [62:0] h, logic [31:0] c, logic [63:0] p);
    req_t r;
    r.kind = k; r.handle = h; r.ctx = c; r.pay = p;
    if (k == KIND_STORE) stores_issued++;
    req_q.push_back(r);
    n_pushed++;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [62:0] pick_handle();
    if ($urandom_range(9) == 0) return 63'(rnd64());
    return 63'($urandom_range(stores_issued + 2, 1));
  endfunction

  function automatic logic [31:0] pick_ctx();
    if ($urandom_range(9) == 0) return $urandom;
    return $urandom_range(5);
  endfunction

  // store_pct and relctx_pct steer the mix; the rest splits lookup/release
  task automatic push_random(int n, int store_pct, int relctx_pct);
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < store_pct)
        push_req(KIND_STORE, 63'(rnd64()), pick_ctx(), rnd64());
      else if (roll < store_pct + relctx_pct)
        push_req(KIND_REL_CTX, 63'(rnd64()), pick_ctx(), rnd64());
      else if (roll[0])
        push_req(KIND_LOOKUP, pick_handle(), $urandom, rnd64());
      else
        push_req(KIND_RELEASE, pick_handle(), $urandom, rnd64());
    end
  endtask

  task automatic drain();
    do @(negedge clk); while (n_taken != n_pushed || rsp_q.size() != 0);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_STORE;
    in_ch.handle = '0;
    in_ch.context_id = '0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_key[i] = '0; tbl_ctx[i] = '0; tbl_pay[i] = '0; tbl_mark[i] = MARK_EMPTY;
    end
    n_live = 0; n_tomb = 0; next_handle = 63'd1;
    send_idle = 0; recv_idle = 0; hold_cycles = 0;
    n_pushed = 0; n_taken = 0; n_err = 0; wdog = 0; took = 0; stores_issued = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: field extremes, every kind, misses and empty context release
    push_req(KIND_LOOKUP, 63'd1, '0, '0);
    push_req(KIND_RELEASE, HANDLE_MAX, '1, '1);
    push_req(KIND_REL_CTX, '0, 32'd7, '0);
    push_req(KIND_STORE, HANDLE_MAX, '0, '0);
    push_req(KIND_STORE, '0, '1, '1);
    push_req(KIND_STORE, 63'(rnd64()), 32'd7, 64'h8000_0000_0000_0001);
    push_req(KIND_STORE, 63'(rnd64()), 32'd7, rnd64());
    push_req(KIND_LOOKUP, 63'd1, '1, '1);
    push_req(KIND_LOOKUP, 63'd2, '0, '0);
    push_req(KIND_LOOKUP, '0, '0, '0);
    push_req(KIND_LOOKUP, HANDLE_MAX, '0, '0);
    push_req(KIND_RELEASE, 63'd1, '0, '0);
    push_req(KIND_RELEASE, 63'd1, '0, '0);
    push_req(KIND_LOOKUP, 63'd1, '0, '0);
    push_req(KIND_REL_CTX, HANDLE_MAX, 32'd7, '1);
    push_req(KIND_REL_CTX, '0, 32'd7, '0);
    push_req(KIND_LOOKUP, 63'd3, '0, '0);
    push_req(KIND_STORE, HANDLE_MAX, '1, rnd64());
    push_req(KIND_REL_CTX, '0, '1, '0);
    push_req(KIND_RELEASE, 63'd2, '1, '1);
    drain();

    push_random(60, 40, 10);
    drain();
    send_idle = 61;
    push_random(60, 45, 10);
    drain();
    send_idle = 0; recv_idle = 61;
    push_random(60, 45, 12);
    drain();
    send_idle = 37; recv_idle = 37;
    push_random(60, 40, 15);
    drain();

    // fill past three-quarter load, then release whole contexts to force sweeps
    send_idle = 0; recv_idle = 0;
    push_random(60, 100, 0);
    push_random(20, 0, 100);
    push_random(30, 70, 5);
    drain();

    // long receiver hold-off while requests keep coming
    hold_cycles = 400;
    push_random(50, 60, 20);
    drain();
    send_idle = 37; recv_idle = 61;
    push_random(30, 50, 20);
    drain();

    repeat (50) @(posedge clk);
    if (n_err == 0 && rsp_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
